FILE: hw/rtl/set_assoc_lru_cache_sim_macros.svh
// Assertion macros shared by the cache simulator RTL.
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold too.
`define SALC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache simulator: implication violated");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define SALC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache simulator: next-cycle implication violated");

`else

`define SALC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SALC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/salc_pkg.sv
// Package with the shared types, codes and defaults of the cache simulator.
`default_nettype none

package salc_pkg;

   // Default sizes of the storage and the address.
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;
   localparam int ADDR_BITS_DEF    = 32;

   // Fixed field widths.
   localparam int OP_W      = 2;
   localparam int OUTCOME_W = 2;
   localparam int CNT_W     = 32;
   localparam int SB_W      = 7;

   // Configuration register port.
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int SET_BITS_W  = 3;
   localparam int OFF_BITS_W  = 5;
   localparam int WAYS_W      = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd2;

   localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
   localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 5'd4;
   localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

   // Access kinds.
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   // Result outcomes.
   localparam logic [OUTCOME_W-1:0] OC_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OC_MISS  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OC_EVICT = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIRST,
      ST_SECOND
   } salc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic clear;
      logic access;
      logic from_reg;
      logic last;
   } salc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_none;
      logic modify;
      logic clr_done;
   } salc_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/salc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/salc_ctrl.sv
// Controller state machine of the cache simulator.
`default_nettype none
`include "set_assoc_lru_cache_sim_macros.svh"

module salc_ctrl
   import salc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire salc_status_type status,
   output salc_cmd_type         cmd
);

   salc_state_type state_ff;
   salc_state_type state_in;

   // State register; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && !status.op_none) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = status.modify ? ST_SECOND : ST_IDLE;
         end
         ST_SECOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_FIRST: begin
            cmd.access = 1'b1;
            cmd.last   = !status.modify;
         end
         ST_SECOND: begin
            cmd.access   = 1'b1;
            cmd.from_reg = 1'b1;
            cmd.last     = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The second access of a modify always follows its first.
   `SALC_ASSERT_IMP(a_second_after_first, clock, reset, state_ff == ST_SECOND, $past(state_ff) == ST_FIRST)
   // An unused op code is taken but starts no access.
   `SALC_ASSERT_NXT(a_none_stays_idle, clock, reset, state_ff == ST_IDLE && start && status.op_none, state_ff == ST_IDLE)
   // A load or store finishes after a single access.
   `SALC_ASSERT_NXT(a_single_access, clock, reset, state_ff == ST_FIRST && !status.modify, state_ff == ST_IDLE)

endmodule

`default_nettype wire

FILE: hw/rtl/salc_dp.sv
// Datapath of the cache simulator: set memory, lookup, LRU update and totals.
`default_nettype none
`include "set_assoc_lru_cache_sim_macros.svh"

module salc_dp
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire salc_cmd_type          cmd,
   output salc_status_type            status,
   input  wire logic [OP_W-1:0]       req_op,
   input  wire logic [ADDR_BITS-1:0]  req_addr,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output logic [OUTCOME_W-1:0]       rsp_outcome,
   output logic                       rsp_last,
   output logic [CNT_W-1:0]           rsp_hit_total,
   output logic [CNT_W-1:0]           rsp_miss_total,
   output logic [CNT_W-1:0]           rsp_evict_total
);

   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int ADR_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W  = RANK_W;
   localparam int TAG_LO = MAX_WAYS + MAX_WAYS * RANK_W;
   localparam int ROW_W  = TAG_LO + MAX_WAYS * ADDR_BITS;

   // Configuration registers.
   logic [SET_BITS_W-1:0] set_bits_ff;
   logic [OFF_BITS_W-1:0] off_bits_ff;
   logic [WAYS_W-1:0]     ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff <= SET_BITS_RST;
         off_bits_ff <= OFF_BITS_RST;
         ways_ff     <= WAYS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS: set_bits_ff <= csr_wdata[SET_BITS_W-1:0];
            CSR_OFF_BITS: off_bits_ff <= csr_wdata[OFF_BITS_W-1:0];
            CSR_WAYS:     ways_ff     <= csr_wdata[WAYS_W-1:0];
            default:      ;
         endcase
      end
   end

   // Address split: set index and tag from the configured bit counts.
   logic [3:0]           set_eff;
   logic [SB_W-1:0]      sb;
   logic [ADDR_BITS-1:0] addr_shifted;
   logic [ADR_W-1:0]     set_mask;
   logic [ADR_W-1:0]     set_calc;
   logic [ADDR_BITS-1:0] tag_calc;

   always_comb begin
      set_eff = (4'(set_bits_ff) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits_ff);
      sb      = SB_W'(set_eff) + SB_W'(off_bits_ff);
      addr_shifted = req_addr >> off_bits_ff;
      for (int i = 0; i < ADR_W; i++) begin
         set_mask[i] = 4'(i) < set_eff;
      end
      set_calc = addr_shifted[ADR_W-1:0] & set_mask;
      tag_calc = (sb >= SB_W'(ADDR_BITS)) ? '0 : (req_addr >> sb);
   end

   // Item registers, loaded when an item is taken.
   logic [ADR_W-1:0]     set_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic [OP_W-1:0]      op_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff <= set_calc;
         tag_ff <= tag_calc;
         op_ff  <= req_op;
      end
   end

   // Clearing sweep counter, one set row per cycle after reset.
   logic [ADR_W-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + ADR_W'(1);
      end
   end

   assign status.clr_done = clr_ff == ADR_W'(SETS - 1);
   assign status.op_none  = req_op == OP_NONE;
   assign status.modify   = op_ff == OP_MODIFY;

   // Set memory: one row holds valid bits, ranks and tags of every way.
   logic [ROW_W-1:0] ram_rdata;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             ram_we;
   logic [ADR_W-1:0] ram_waddr;
   logic [ROW_W-1:0] ram_wdata;

   assign ram_we    = cmd.clear || cmd.access;
   assign ram_waddr = cmd.clear ? clr_ff : set_ff;
   assign ram_wdata = cmd.clear ? '0 : row_in;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (set_calc),
      .rd_data (ram_rdata)
   );

   // Lookup, victim choice and recency update on the selected row.
   logic [4:0]           ways_eff;
   logic [ROW_W-1:0]     row_cur;
   logic [MAX_WAYS-1:0]  in_use;
   logic [MAX_WAYS-1:0]  v_cur;
   logic [RANK_W-1:0]    r_cur [MAX_WAYS];
   logic [ADDR_BITS-1:0] t_cur [MAX_WAYS];
   logic [MAX_WAYS-1:0]  hit_vec;
   logic [MAX_WAYS-1:0]  inv_vec;
   logic                 hit_any;
   logic                 inv_any;
   logic [WAY_W-1:0]     hit_way;
   logic [WAY_W-1:0]     fill_way;
   logic [WAY_W-1:0]     victim;
   logic [RANK_W-1:0]    best;
   logic [WAY_W-1:0]     target;
   logic [RANK_W:0]      old_rank;
   logic [OUTCOME_W-1:0] outcome;

   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = 5'd1;
      end else if (5'(ways_ff) > 5'(MAX_WAYS)) begin
         ways_eff = 5'(MAX_WAYS);
      end else begin
         ways_eff = 5'(ways_ff);
      end
      row_cur = cmd.from_reg ? row_ff : ram_rdata;

      // Unpack the row and flag matching and free ways.
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]  = 5'(w) < ways_eff;
         v_cur[w]   = row_cur[w];
         r_cur[w]   = row_cur[MAX_WAYS + w * RANK_W +: RANK_W];
         t_cur[w]   = row_cur[TAG_LO + w * ADDR_BITS +: ADDR_BITS];
         hit_vec[w] = in_use[w] && v_cur[w] && (t_cur[w] == tag_ff);
         inv_vec[w] = in_use[w] && !v_cur[w];
      end
      hit_any = |hit_vec;
      inv_any = |inv_vec;

      // Lowest-numbered matching way and lowest-numbered free way.
      hit_way  = '0;
      fill_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (inv_vec[w]) begin
            fill_way = WAY_W'(w);
         end
      end

      // Oldest in-use way; ties go to the lower way.
      best   = r_cur[0];
      victim = '0;
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && (r_cur[w] > best)) begin
            best   = r_cur[w];
            victim = WAY_W'(w);
         end
      end

      if (hit_any) begin
         target  = hit_way;
         outcome = OC_HIT;
      end else if (inv_any) begin
         target  = fill_way;
         outcome = OC_MISS;
      end else begin
         target  = victim;
         outcome = OC_EVICT;
      end

      // A freshly filled way counts as older than every other way.
      old_rank = inv_any && !hit_any ? (RANK_W + 1)'(MAX_WAYS) : {1'b0, r_cur[target]};

      // Build the updated row.
      row_in = row_cur;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WAY_W'(w) == target) begin
            row_in[w] = 1'b1;
            row_in[MAX_WAYS + w * RANK_W +: RANK_W]   = '0;
            row_in[TAG_LO + w * ADDR_BITS +: ADDR_BITS] = tag_ff;
         end else if (in_use[w] && v_cur[w] && ({1'b0, r_cur[w]} < old_rank) &&
                      (r_cur[w] < RANK_W'(MAX_WAYS - 1))) begin
            row_in[MAX_WAYS + w * RANK_W +: RANK_W] = r_cur[w] + RANK_W'(1);
         end
      end
   end

   // Working copy of the row, used by the second access of a modify.
   always_ff @(posedge clock) begin
      if (cmd.access) begin
         row_ff <= row_in;
      end
   end

   // Running totals.
   logic [CNT_W-1:0] hit_cnt_ff;
   logic [CNT_W-1:0] miss_cnt_ff;
   logic [CNT_W-1:0] evict_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else if (cmd.access) begin
         if (hit_any) begin
            hit_cnt_ff <= hit_cnt_ff + CNT_W'(1);
         end else begin
            miss_cnt_ff <= miss_cnt_ff + CNT_W'(1);
         end
         if (!hit_any && !inv_any) begin
            evict_cnt_ff <= evict_cnt_ff + CNT_W'(1);
         end
      end
   end

   // Result register: each result shows for one cycle after its access.
   logic                 rsp_valid_ff;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic                 rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.access;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         rsp_outcome_ff <= outcome;
         rsp_last_ff    <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_hit_total   = hit_cnt_ff;
   assign rsp_miss_total  = miss_cnt_ff;
   assign rsp_evict_total = evict_cnt_ff;

   // Every result adds exactly one to the hit and miss totals together.
   `SALC_ASSERT_IMP(a_one_count_per_result, clock, reset, rsp_valid_ff, CNT_W'(hit_cnt_ff + miss_cnt_ff) == CNT_W'($past(hit_cnt_ff) + $past(miss_cnt_ff) + CNT_W'(1)))
   // An eviction result is always counted as an eviction.
   `SALC_ASSERT_IMP(a_evict_counted, clock, reset, rsp_valid_ff && rsp_outcome_ff == OC_EVICT, evict_cnt_ff == CNT_W'($past(evict_cnt_ff) + CNT_W'(1)))
   // A first access works on the row read for the item taken just before.
   `SALC_ASSERT_IMP(a_read_before_access, clock, reset, cmd.access && !cmd.from_reg, $past(cmd.capture))

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_sim.sv
// Top level of the set-associative LRU cache simulator.
//
//   Channel   Ports                                        Transfer
//   request   start, busy, req_op, req_addr                start high, busy low
//   response  rsp_valid, rsp_outcome, rsp_last, rsp_*_total one cycle per strobe
//   config    csr_we, csr_index, csr_wdata                 csr_we high
//
// After reset the set memory is swept clear, one set row per cycle, with busy
// held high. For a load or store the set row is read on the accepting edge
// and looked up, updated and written back in the next cycle. A modify makes
// a second access, which works on the updated row held in the datapath. The
// result strobe is registered and comes in the cycle after each access.
// The receiver cannot stall; an unused op code is taken and gives no result.
`default_nettype none

module set_assoc_lru_cache_sim
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [OP_W-1:0]       req_op,
   input  wire logic [ADDR_BITS-1:0]  req_addr,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output logic [OUTCOME_W-1:0]       rsp_outcome,
   output logic                       rsp_last,
   output logic [CNT_W-1:0]           rsp_hit_total,
   output logic [CNT_W-1:0]           rsp_miss_total,
   output logic [CNT_W-1:0]           rsp_evict_total
);

   salc_cmd_type    cmd;
   salc_status_type status;

   // Sequencing of clear sweep and accesses.
   salc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Set memory, lookup and totals.
   salc_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_addr        (req_addr),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_outcome     (rsp_outcome),
      .rsp_last        (rsp_last),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total)
   );

endmodule

`default_nettype wire

FILE: tb/set_assoc_lru_cache_sim_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the set-associative LRU cache simulator, with its own LRU predictor.
module set_assoc_lru_cache_sim_tb
   import salc_pkg::*;
();

   localparam int WAYS_MAX      = MAX_WAYS_DEF;
   localparam int SET_BITS_MAX  = MAX_SET_BITS_DEF;
   localparam int LINES         = (1 << SET_BITS_MAX) * WAYS_MAX;
   localparam int ADDR_W        = ADDR_BITS_DEF;
   localparam int ITEM_TARGET   = 850;
   localparam int DRAIN_LIMIT   = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int DIRECTED_ROWS = 31;

   // One result as the block should present it.
   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic                 last;
      logic [CNT_W-1:0]     hit_total;
      logic [CNT_W-1:0]     miss_total;
      logic [CNT_W-1:0]     evict_total;
   } cache_result_type;

   // One row of the directed sequence: an access or a register write.
   typedef enum logic {
      STEP_ACCESS,
      STEP_CSR_WRITE
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [OP_W-1:0]       op;
      logic [ADDR_W-1:0]     addr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      logic                  typed;
      logic [OUTCOME_W-1:0]  outcome_a;
      logic [OUTCOME_W-1:0]  outcome_b;
   } step_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic [OP_W-1:0]       req_op    = OP_LOAD;
   logic [ADDR_W-1:0]     req_addr  = '0;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SET_BITS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [OUTCOME_W-1:0]  rsp_outcome;
   logic                  rsp_last;
   logic [CNT_W-1:0]      rsp_hit_total;
   logic [CNT_W-1:0]      rsp_miss_total;
   logic [CNT_W-1:0]      rsp_evict_total;

   // Predictor state: lines, recency ages, totals and the register copy.
   bit                    way_valid [LINES];
   logic [ADDR_W-1:0]     way_tag [LINES];
   int unsigned           way_age [LINES];
   logic [CNT_W-1:0]      hits      = '0;
   logic [CNT_W-1:0]      misses    = '0;
   logic [CNT_W-1:0]      evictions = '0;
   logic [SET_BITS_W-1:0] cfg_set_bits = SET_BITS_RST;
   logic [OFF_BITS_W-1:0] cfg_off_bits = OFF_BITS_RST;
   logic [WAYS_W-1:0]     cfg_ways     = WAYS_RST;

   cache_result_type      pending_results [$];
   int unsigned           mismatch_count = 0;
   bit                    gaps_on        = 1'b1;
   logic [ADDR_W-1:0]     phase_tag_base = '0;

   // Directed sequence under the reset settings first, then the extremes.
   step_type directed_steps [DIRECTED_ROWS] = '{
      '{STEP_ACCESS,    OP_LOAD,   32'h0000_0000, CSR_SET_BITS, 5'd0,  1'b1, OC_MISS,  OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h0000_000C, CSR_SET_BITS, 5'd0,  1'b1, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_MODIFY, 32'h0000_0100, CSR_SET_BITS, 5'd0,  1'b1, OC_EVICT, OC_HIT},
      '{STEP_ACCESS,    OP_NONE,   32'hDEAD_BEEF, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_STORE,  32'hFFFF_FFFF, CSR_SET_BITS, 5'd0,  1'b1, OC_MISS,  OC_HIT},
      '{STEP_ACCESS,    OP_MODIFY, 32'hFFFF_FFF0, CSR_SET_BITS, 5'd0,  1'b1, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h8000_0000, CSR_SET_BITS, 5'd0,  1'b1, OC_EVICT, OC_HIT},
      '{STEP_ACCESS,    OP_STORE,  32'h7FFF_FFFF, CSR_SET_BITS, 5'd0,  1'b1, OC_EVICT, OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_WAYS,     5'd8,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_OFF_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h0080_0000, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h0000_0001, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_STORE,  32'h0000_0002, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_MODIFY, 32'h0000_0003, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_WAYS,     5'd1,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h0000_0002, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_WAYS,     5'd2,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h0000_0002, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_SET_BITS, 5'd7,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_OFF_BITS, 5'd31, 1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_WAYS,     5'd15, 1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h8000_0000, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h0000_0000, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_STORE,  32'h7FFF_FFFF, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_OFF_BITS, 5'd26, 1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_SET_BITS, 5'd6,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_MODIFY, 32'hFC00_0000, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h03FF_FFFF, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_CSR_WRITE, OP_LOAD,   32'h0000_0000, CSR_WAYS,     5'd0,  1'b0, OC_HIT,   OC_HIT},
      '{STEP_ACCESS,    OP_LOAD,   32'h1234_5678, CSR_SET_BITS, 5'd0,  1'b0, OC_HIT,   OC_HIT}
   };

   set_assoc_lru_cache_sim i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_addr        (req_addr),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_outcome     (rsp_outcome),
      .rsp_last        (rsp_last),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_evict_total (rsp_evict_total)
   );

   // Free-running clock with an 8 ns period.
   initial begin
      forever #4 clock = ~clock;
   end

   // Hard limit on the run, well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("set_assoc_lru_cache_sim test failed");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want);
      if (got !== want) begin
         report_error($sformatf("%s: got %0h, expected %0h", name, got, want));
      end
   endtask

   // Number of ways that take part in lookups with the current setting.
   function automatic int unsigned ways_active();
      if (cfg_ways == 0) return 1;
      if (cfg_ways > WAYS_MAX) return WAYS_MAX;
      return cfg_ways;
   endfunction

   // Make a way most recent; younger valid ways age by one, saturating.
   // A way that was just filled counts as older than every other way.
   function automatic void promote_way(input int unsigned base, input int unsigned ways,
                                       input int unsigned w, input bit was_valid);
      int unsigned prev_age;
      prev_age = was_valid ? way_age[base + w] : WAYS_MAX;
      for (int unsigned v = 0; v < ways; v++) begin
         if (v != w && way_valid[base + v] && way_age[base + v] < prev_age &&
             way_age[base + v] < WAYS_MAX - 1) begin
            way_age[base + v]++;
         end
      end
      way_age[base + w] = 0;
   endfunction

   // One lookup in a set: hit, fill of the lowest free way, or LRU replacement.
   function automatic logic [OUTCOME_W-1:0] cache_lookup(input int unsigned set_idx,
                                                         input logic [ADDR_W-1:0] tag);
      int unsigned ways;
      int unsigned base;
      int unsigned victim;
      int unsigned oldest;
      ways = ways_active();
      base = set_idx * WAYS_MAX;
      for (int unsigned w = 0; w < ways; w++) begin
         if (way_valid[base + w] && way_tag[base + w] == tag) begin
            promote_way(base, ways, w, 1'b1);
            hits++;
            return OC_HIT;
         end
      end
      misses++;
      for (int unsigned w = 0; w < ways; w++) begin
         if (!way_valid[base + w]) begin
            way_valid[base + w] = 1'b1;
            way_tag[base + w]   = tag;
            promote_way(base, ways, w, 1'b0);
            return OC_MISS;
         end
      end
      // Set full: the oldest way goes, the lowest-numbered on a tie.
      victim = 0;
      oldest = way_age[base];
      for (int unsigned w = 1; w < ways; w++) begin
         if (way_age[base + w] > oldest) begin
            oldest = way_age[base + w];
            victim = w;
         end
      end
      way_tag[base + victim] = tag;
      promote_way(base, ways, victim, 1'b1);
      evictions++;
      return OC_EVICT;
   endfunction

   // Works out the results of an accepted access and queues them.
   // A typed row replaces the predicted outcomes with the ones written in the table.
   function automatic void predict_access(input logic [OP_W-1:0] op,
                                          input logic [ADDR_W-1:0] addr, input bit typed,
                                          input logic [OUTCOME_W-1:0] outcome_a,
                                          input logic [OUTCOME_W-1:0] outcome_b);
      int unsigned      set_bits_eff;
      int unsigned      shift_total;
      int unsigned      set_idx;
      logic [63:0]      wide;
      logic [ADDR_W-1:0] tag;
      cache_result_type res;
      if (op == OP_NONE) return;
      set_bits_eff = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
      wide         = 64'(addr) >> cfg_off_bits;
      set_idx      = int'(wide & ((64'd1 << set_bits_eff) - 64'd1));
      shift_total  = set_bits_eff + cfg_off_bits;
      tag          = (shift_total >= ADDR_W) ? '0 : addr >> shift_total;

      res.outcome = cache_lookup(set_idx, tag);
      if (typed) res.outcome = outcome_a;
      res.last        = (op != OP_MODIFY);
      res.hit_total   = hits;
      res.miss_total  = misses;
      res.evict_total = evictions;
      pending_results.push_back(res);

      // A modify repeats the access as a store on the same line.
      if (op == OP_MODIFY) begin
         res.outcome = cache_lookup(set_idx, tag);
         if (typed) res.outcome = outcome_b;
         res.last        = 1'b1;
         res.hit_total   = hits;
         res.miss_total  = misses;
         res.evict_total = evictions;
         pending_results.push_back(res);
      end
   endfunction

   // Address near a few sets and a handful of tags, so that hits and evictions are common.
   function automatic logic [ADDR_W-1:0] make_addr();
      int unsigned set_bits_eff;
      logic [63:0] addr_wide;
      logic [63:0] tag_v;
      logic [63:0] set_v;
      logic [63:0] off_v;
      if ($urandom_range(0, 4) == 0) return $urandom;
      set_bits_eff = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_set_bits;
      tag_v = 64'(phase_tag_base ^ $urandom_range(0, ways_active() + 2));
      set_v = 64'($urandom_range(0, 3)) & ((64'd1 << set_bits_eff) - 64'd1);
      off_v = 64'($urandom) & ((64'd1 << cfg_off_bits) - 64'd1);
      addr_wide = (tag_v << (set_bits_eff + cfg_off_bits)) | (set_v << cfg_off_bits) | off_v;
      return addr_wide[ADDR_W-1:0];
   endfunction

   // Presents one access after a random gap, if gaps are on, and holds it until the transfer.
   task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input bit typed, input logic [OUTCOME_W-1:0] outcome_a,
                              input logic [OUTCOME_W-1:0] outcome_b);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_op   <= op;
      req_addr <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_access(op, addr, typed, outcome_a, outcome_b);
   endtask

   // Waits until every expected result is in and the block has gone idle.
   task automatic wait_idle();
      start <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) begin
         @(posedge clock);
      end
      if (pending_results.size() != 0) begin
         report_error($sformatf("%0d expected results never arrived", pending_results.size()));
         pending_results.delete();
      end
      // An ignored op code leaves no result behind, so allow it time to finish.
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SET_BITS: begin
            cfg_set_bits = val[SET_BITS_W-1:0];
         end
         CSR_OFF_BITS: begin
            cfg_off_bits = val[OFF_BITS_W-1:0];
         end
         CSR_WAYS: begin
            cfg_ways = val[WAYS_W-1:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Result checker: every strobe is one transfer and must match the oldest expectation.
   always @(posedge clock) begin
      cache_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("result with nothing expected, outcome %0d", rsp_outcome));
         end else begin
            want = pending_results.pop_front();
            check_field("outcome", CNT_W'(rsp_outcome), CNT_W'(want.outcome));
            check_field("last", CNT_W'(rsp_last), CNT_W'(want.last));
            check_field("hit_total", rsp_hit_total, want.hit_total);
            check_field("miss_total", rsp_miss_total, want.miss_total);
            check_field("evict_total", rsp_evict_total, want.evict_total);
         end
      end
   end

   // Stimulus: reset, the directed table, then random phases of settings and accesses.
   initial begin : stimulus
      int unsigned      items_done;
      int unsigned      phase;
      int unsigned      phase_len;
      logic [OP_W-1:0]  op;
      step_type         step;
      items_done = 0;
      phase      = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // The clearing sweep after reset keeps busy high; wait_idle covers it.
      wait_idle();

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         step = directed_steps[i];
         if (step.kind == STEP_CSR_WRITE) begin
            wait_idle();
            write_csr(step.csr_idx, step.csr_val);
         end else begin
            send_access(step.op, step.addr, step.typed, step.outcome_a, step.outcome_b);
         end
      end

      while (items_done < ITEM_TARGET) begin
         wait_idle();
         // The first phases visit the corners of the settings, the rest are drawn.
         case (phase)
            0: begin
               write_csr(CSR_SET_BITS, 5'd0);
               write_csr(CSR_OFF_BITS, 5'd0);
               write_csr(CSR_WAYS, 5'd1);
            end
            1: begin
               write_csr(CSR_SET_BITS, 5'd6);
               write_csr(CSR_OFF_BITS, 5'd26);
               write_csr(CSR_WAYS, 5'd8);
            end
            2: begin
               write_csr(CSR_SET_BITS, 5'd7);
               write_csr(CSR_OFF_BITS, 5'd31);
               write_csr(CSR_WAYS, 5'd15);
            end
            3: begin
               write_csr(CSR_SET_BITS, 5'd2);
               write_csr(CSR_OFF_BITS, 5'd2);
               write_csr(CSR_WAYS, 5'd0);
            end
            default: begin
               write_csr(CSR_SET_BITS, CSR_DATA_W'($urandom_range(0, 7)));
               if ($urandom_range(0, 3) == 0) begin
                  write_csr(CSR_OFF_BITS, CSR_DATA_W'($urandom_range(0, 31)));
               end else begin
                  write_csr(CSR_OFF_BITS, CSR_DATA_W'($urandom_range(0, 8)));
               end
               write_csr(CSR_WAYS, CSR_DATA_W'($urandom_range(0, 15)));
            end
         endcase
         phase_tag_base = ($urandom_range(0, 1) == 0) ? '0 : ADDR_W'($urandom);
         gaps_on        = ($urandom_range(0, 3) != 0);
         phase_len      = $urandom_range(40, 100);

         // Every transfer counts, ignored op codes included.
         for (int n = 0; n < phase_len && items_done < ITEM_TARGET; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               op = OP_NONE;
            end else begin
               case ($urandom_range(0, 2))
                  0: op = OP_LOAD;
                  1: op = OP_STORE;
                  default: op = OP_MODIFY;
               endcase
            end
            send_access(op, make_addr(), 1'b0, OC_HIT, OC_HIT);
            items_done++;
         end
         phase++;
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("set_assoc_lru_cache_sim test passed");
      end else begin
         $display("set_assoc_lru_cache_sim test failed");
      end
      $finish;
   end

endmodule
